FILE: rtl/core/ped_pkg.sv
package ped_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int CSR_ADDR_W    = 5;
   localparam int CSR_IDX_W     = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_GRAV_X      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRAV_Y      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GRAV_Z      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_START_COLOR = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_END_COLOR   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_START_SIZE  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_END_SIZE    = 3'd6;

   localparam logic [31:0] START_COLOR_RST = 32'hFFFF_FFFF;
   localparam logic [30:0] START_SIZE_RST  = 31'd65536;

   // blend factor selection codes
   localparam logic [1:0] TSEL_FULL = 2'd0;
   localparam logic [1:0] TSEL_ZERO = 2'd1;
   localparam logic [1:0] TSEL_DIV  = 2'd2;

   typedef logic [2:0][31:0] vec3_type;

   typedef struct packed {
      logic        alive_in;
      logic [31:0] pos_x_in;
      logic [31:0] pos_y_in;
      logic [31:0] pos_z_in;
      logic [31:0] vel_x_in;
      logic [31:0] vel_y_in;
      logic [31:0] vel_z_in;
      logic [31:0] life_in;
      logic [30:0] max_life;
      logic [30:0] time_step;
   } req_payload_type;

   typedef struct packed {
      logic        alive_out;
      logic [31:0] pos_x_out;
      logic [31:0] pos_y_out;
      logic [31:0] pos_z_out;
      logic [31:0] vel_x_out;
      logic [31:0] vel_y_out;
      logic [31:0] vel_z_out;
      logic [31:0] life_out;
      logic [31:0] color_out;
      logic [30:0] size_out;
   } rsp_payload_type;

   // flags carried alongside the arithmetic
   typedef struct packed {
      logic        upd;
      logic        live;
      logic [31:0] life;
   } side_type;

   // a + b saturated to signed 32 bits, b already scaled
   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [63:0] b);
      logic signed [63:0] s;
      s = $signed({{32{a[31]}}, a}) + $signed(b);
      if (s > 64'sh0000_0000_7FFF_FFFF)       sat_add = 32'h7FFF_FFFF;
      else if (s < -64'sh0000_0000_8000_0000) sat_add = 32'h8000_0000;
      else                                     sat_add = s[31:0];
   endfunction

endpackage

FILE: rtl/core/ped_kin.sv
module ped_kin #(
   parameter int FRAC_BITS = ped_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              advance,
   input  logic              upd,
   input  ped_pkg::vec3_type pos,
   input  ped_pkg::vec3_type vel,
   input  ped_pkg::vec3_type grav,
   input  logic [30:0]       dt,
   output ped_pkg::vec3_type pos_o,
   output ped_pkg::vec3_type vel_o
);
   import ped_pkg::*;

   logic [2:0][63:0] ga_ff, ga_in;
   vec3_type         pos_a_ff, vel_a_ff;
   logic [30:0]      dt_a_ff;
   logic             upd_a_ff;

   vec3_type         vel_b_ff, vel_b_in, pos_b_ff;
   logic [30:0]      dt_b_ff;
   logic             upd_b_ff;

   logic [2:0][63:0] pv_ff, pv_in;
   vec3_type         vel_c_ff, pos_c_ff;
   logic             upd_c_ff;

   vec3_type         pos_d_ff, pos_d_in, vel_d_ff;

   always_comb begin
      logic signed [63:0] sh;
      for (int i = 0; i < 3; i++) begin
         ga_in[i] = 64'($signed(grav[i]) * $signed({1'b0, dt}));
         sh = $signed(ga_ff[i]) >>> FRAC_BITS;
         vel_b_in[i] = upd_a_ff ? sat_add(vel_a_ff[i], sh) : vel_a_ff[i];
         pv_in[i] = 64'($signed(vel_b_ff[i]) * $signed({1'b0, dt_b_ff}));
         sh = $signed(pv_ff[i]) >>> FRAC_BITS;
         pos_d_in[i] = upd_c_ff ? sat_add(pos_c_ff[i], sh) : pos_c_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ga_ff    <= ga_in;
         pos_a_ff <= pos;
         vel_a_ff <= vel;
         dt_a_ff  <= dt;
         upd_a_ff <= upd;
         vel_b_ff <= vel_b_in;
         pos_b_ff <= pos_a_ff;
         dt_b_ff  <= dt_a_ff;
         upd_b_ff <= upd_a_ff;
         pv_ff    <= pv_in;
         vel_c_ff <= vel_b_ff;
         pos_c_ff <= pos_b_ff;
         upd_c_ff <= upd_b_ff;
         pos_d_ff <= pos_d_in;
         vel_d_ff <= vel_c_ff;
      end
   end

   assign pos_o = pos_d_ff;
   assign vel_o = vel_d_ff;

endmodule

FILE: rtl/core/ped_divider.sv
module ped_divider #(
   parameter int FRAC_BITS = ped_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               advance,
   input  logic [30:0]        max_life,
   input  logic [31:0]        life,
   output logic [FRAC_BITS:0] t
);
   import ped_pkg::*;

   localparam logic [FRAC_BITS:0] T_FULL = (FRAC_BITS+1)'(1) << FRAC_BITS;

   logic [1:0]  sel0;
   logic [30:0] rem0;

   logic [30:0]          rem_ff [FRAC_BITS];
   logic [30:0]          rem_in [FRAC_BITS];
   logic [FRAC_BITS-1:0] quo_ff [FRAC_BITS];
   logic [FRAC_BITS-1:0] quo_in [FRAC_BITS];
   logic [30:0]          den_ff [FRAC_BITS];
   logic [1:0]           sel_ff [FRAC_BITS];

   // special cases first, then one quotient bit per stage
   always_comb begin
      rem0 = max_life - life[30:0];
      if ($signed(life) <= 32'sd0 || max_life == 31'd0) begin
         sel0 = TSEL_FULL;
      end else if (life[30:0] >= max_life) begin
         sel0 = TSEL_ZERO;
      end else begin
         sel0 = TSEL_DIV;
      end
   end

   for (genvar k = 0; k < FRAC_BITS; k++) begin : g_step
      logic [30:0]          rem_p;
      logic [FRAC_BITS-1:0] quo_p;
      logic [30:0]          den_p;
      logic [1:0]           sel_p;
      logic [31:0]          sh;

      if (k == 0) begin : g_first
         assign rem_p = rem0;
         assign quo_p = '0;
         assign den_p = max_life;
         assign sel_p = sel0;
      end else begin : g_next
         assign rem_p = rem_ff[k-1];
         assign quo_p = quo_ff[k-1];
         assign den_p = den_ff[k-1];
         assign sel_p = sel_ff[k-1];
      end

      always_comb begin
         sh = {rem_p, 1'b0};
         if (sh >= {1'b0, den_p}) begin
            rem_in[k] = 31'(sh - {1'b0, den_p});
            quo_in[k] = {quo_p[FRAC_BITS-2:0], 1'b1};
         end else begin
            rem_in[k] = sh[30:0];
            quo_in[k] = {quo_p[FRAC_BITS-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
            den_ff[k] <= den_p;
            sel_ff[k] <= sel_p;
         end
      end
   end

   always_comb begin
      unique case (sel_ff[FRAC_BITS-1])
         TSEL_FULL: t = T_FULL;
         TSEL_ZERO: t = '0;
         default:   t = {1'b0, quo_ff[FRAC_BITS-1]};
      endcase
   end

endmodule

FILE: rtl/core/ped_blend.sv
module ped_blend #(
   parameter int FRAC_BITS = ped_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               advance,
   input  logic [FRAC_BITS:0] t,
   input  logic [31:0]        start_color,
   input  logic [31:0]        end_color,
   input  logic [30:0]        start_size,
   input  logic [30:0]        end_size,
   output logic [31:0]        color,
   output logic [30:0]        size
);
   import ped_pkg::*;

   localparam logic [FRAC_BITS:0] T_FULL = (FRAC_BITS+1)'(1) << FRAC_BITS;

   logic [FRAC_BITS:0]      tn;
   logic [3:0][FRAC_BITS+8:0]  cs_ff, ce_ff;
   logic [FRAC_BITS+31:0]   ss_ff, se_ff;
   logic [31:0]             color_ff, color_in;
   logic [30:0]             size_ff, size_in;

   assign tn = T_FULL - t;

   always_comb begin
      logic [FRAC_BITS+9:0]  csum;
      logic [FRAC_BITS+32:0] ssum;
      for (int i = 0; i < 4; i++) begin
         csum = {1'b0, cs_ff[i]} + {1'b0, ce_ff[i]};
         color_in[8*i +: 8] = csum[FRAC_BITS +: 8];
      end
      ssum = {1'b0, ss_ff} + {1'b0, se_ff};
      size_in = ssum[FRAC_BITS +: 31];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 4; i++) begin
            cs_ff[i] <= start_color[8*i +: 8] * tn;
            ce_ff[i] <= end_color[8*i +: 8] * t;
         end
         ss_ff    <= start_size * tn;
         se_ff    <= end_size * t;
         color_ff <= color_in;
         size_ff  <= size_in;
      end
   end

   assign color = color_ff;
   assign size  = size_ff;

endmodule

FILE: rtl/core/particle_euler_update.sv
// throughput: one item per cycle while the output is not stalled; the life fraction divider retires one
// quotient bit per stage, which sets the depth
// the whole pipe holds only while the output item waits and rsp_ready is low
// reset (synchronous, active high) clears valid bits and loads register defaults
module particle_euler_update #(
   parameter int FRAC_BITS = ped_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  ped_pkg::req_payload_type       req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output ped_pkg::rsp_payload_type       rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [ped_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);
   import ped_pkg::*;

   localparam int DEPTH = FRAC_BITS + 3;

   // configuration registers
   logic [31:0] grav_x_ff, grav_y_ff, grav_z_ff, start_color_ff, end_color_ff;
   logic [30:0] start_size_ff, end_size_ff;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic csr_wr;

   assign pready  = 1'b1;
   assign csr_idx = paddr[CSR_ADDR_W-1:2];
   assign csr_wr  = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         grav_x_ff      <= '0;
         grav_y_ff      <= '0;
         grav_z_ff      <= '0;
         start_color_ff <= START_COLOR_RST;
         end_color_ff   <= '0;
         start_size_ff  <= START_SIZE_RST;
         end_size_ff    <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_GRAV_X:      grav_x_ff      <= pwdata;
            REG_GRAV_Y:      grav_y_ff      <= pwdata;
            REG_GRAV_Z:      grav_z_ff      <= pwdata;
            REG_START_COLOR: start_color_ff <= pwdata;
            REG_END_COLOR:   end_color_ff   <= pwdata;
            REG_START_SIZE:  start_size_ff  <= pwdata[30:0];
            REG_END_SIZE:    end_size_ff    <= pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_GRAV_X:      prdata = grav_x_ff;
         REG_GRAV_Y:      prdata = grav_y_ff;
         REG_GRAV_Z:      prdata = grav_z_ff;
         REG_START_COLOR: prdata = start_color_ff;
         REG_END_COLOR:   prdata = end_color_ff;
         REG_START_SIZE:  prdata = {1'b0, start_size_ff};
         REG_END_SIZE:    prdata = {1'b0, end_size_ff};
         default:         prdata = '0;
      endcase
   end

   // global pipe enable: move unless the finished item is stuck at the output
   logic advance;
   logic [DEPTH-1:0] vld_ff;

   assign advance   = ~vld_ff[DEPTH-1] | rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = vld_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_valid};
      end
   end

   // first stage: capture item and reduce life (saturating)
   logic signed [32:0] life_diff;
   logic [31:0]        life_red;
   vec3_type           pos1_ff, vel1_ff;
   logic [31:0]        life1_ff;
   logic [30:0]        maxl1_ff, dt1_ff;
   logic               live1_ff, upd1_ff;

   always_comb begin
      life_diff = $signed({req_data.life_in[31], req_data.life_in})
                - $signed({2'b00, req_data.time_step});
      if (life_diff < -33'sh0_8000_0000) life_red = 32'h8000_0000;
      else                               life_red = life_diff[31:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pos1_ff  <= {req_data.pos_z_in, req_data.pos_y_in, req_data.pos_x_in};
         vel1_ff  <= {req_data.vel_z_in, req_data.vel_y_in, req_data.vel_x_in};
         life1_ff <= req_data.alive_in ? life_red : req_data.life_in;
         maxl1_ff <= req_data.max_life;
         dt1_ff   <= req_data.time_step;
         live1_ff <= req_data.alive_in;
         // a live particle moves only if life is still positive
         upd1_ff  <= req_data.alive_in & ($signed(life_red) > 32'sd0);
      end
   end

   // motion: velocity then position, four stages
   vec3_type pos_k, vel_k;

   ped_kin #(.FRAC_BITS(FRAC_BITS)) u_kin (
      .clock   (clock),
      .advance (advance),
      .upd     (upd1_ff),
      .pos     (pos1_ff),
      .vel     (vel1_ff),
      .grav    ({grav_z_ff, grav_y_ff, grav_x_ff}),
      .dt      (dt1_ff),
      .pos_o   (pos_k),
      .vel_o   (vel_k)
   );

   // life fraction, FRAC_BITS stages
   logic [FRAC_BITS:0] t_frac;

   ped_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock    (clock),
      .advance  (advance),
      .max_life (maxl1_ff),
      .life     (life1_ff),
      .t        (t_frac)
   );

   // color and size blend, two stages
   logic [31:0] color_b;
   logic [30:0] size_b;

   ped_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
      .clock       (clock),
      .advance     (advance),
      .t           (t_frac),
      .start_color (start_color_ff),
      .end_color   (end_color_ff),
      .start_size  (start_size_ff),
      .end_size    (end_size_ff),
      .color       (color_b),
      .size        (size_b)
   );

   // align flags and motion results with the blend output
   side_type side_ff [DEPTH-1];
   vec3_type kpos_ff [FRAC_BITS-2];
   vec3_type kvel_ff [FRAC_BITS-2];

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= '{upd: upd1_ff, live: live1_ff, life: life1_ff};
         for (int j = 1; j < DEPTH-1; j++) side_ff[j] <= side_ff[j-1];
         kpos_ff[0] <= pos_k;
         kvel_ff[0] <= vel_k;
         for (int j = 1; j < FRAC_BITS-2; j++) begin
            kpos_ff[j] <= kpos_ff[j-1];
            kvel_ff[j] <= kvel_ff[j-1];
         end
      end
   end

   side_type side_o;
   vec3_type pos_o, vel_o;

   assign side_o = side_ff[DEPTH-2];
   assign pos_o  = kpos_ff[FRAC_BITS-3];
   assign vel_o  = kvel_ff[FRAC_BITS-3];

   // a particle that arrives dead reports no color and no size
   always_comb begin
      rsp_data.alive_out = side_o.upd;
      rsp_data.pos_x_out = pos_o[0];
      rsp_data.pos_y_out = pos_o[1];
      rsp_data.pos_z_out = pos_o[2];
      rsp_data.vel_x_out = vel_o[0];
      rsp_data.vel_y_out = vel_o[1];
      rsp_data.vel_z_out = vel_o[2];
      rsp_data.life_out  = side_o.life;
      rsp_data.color_out = side_o.live ? color_b : 32'd0;
      rsp_data.size_out  = side_o.live ? size_b : 31'd0;
   end

endmodule

FILE: sim/tb_particle_euler_update.sv
module tb_particle_euler_update;
   timeunit 1ns;
   timeprecision 1ps;
   import ped_pkg::*;

   localparam int FRAC       = FRAC_BITS_DEF;
   localparam int STALL_MAX  = 3000;  // cycles with no item moving on either side
   localparam int SETTLE     = FRAC + 12;
   localparam int HOLD_LEN   = 90;    // long receiver stall, deeper than the pipe
   localparam int PHASE_LEN  = 230;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_payload_type       req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_payload_type       rsp_data;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]           pwdata = '0;
   logic [31:0]           prdata;
   logic                  pready;

   particle_euler_update dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // shadow copy of the block's registers
   logic [31:0] grav_shadow [3];
   logic [31:0] start_color_sh, end_color_sh;
   logic [30:0] start_size_sh, end_size_sh;

   rsp_payload_type particle_q[$];   // results still owed by the block
   int  fail_count = 0;
   bit  calm = 1'b0;                 // no idling on either side while set
   int  hold_reqs = 0;               // bumped to ask the receiver for a long stall

   function automatic longint clamp32(longint x);
      if (x > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
      if (x < -64'sh8000_0000) return -64'sh8000_0000;
      return x;
   endfunction

   // s*(1-t) + e*t with t in Q1.FRAC, truncated
   function automatic longint unsigned lerp_q(longint unsigned s, longint unsigned e,
                                              longint unsigned t);
      longint unsigned one;
      one = longint'(1) << FRAC;
      return (s * (one - t) + e * t) >> FRAC;
   endfunction

   // one Euler step of one particle with the current register settings
   function automatic rsp_payload_type advance_particle(req_payload_type r);
      rsp_payload_type o;
      longint          life, dtv, g;
      longint          pos [3];
      longint          vel [3];
      longint unsigned t, maxl, one, color, sz;
      bit              alive;
      logic [31:0]     pin [3];
      logic [31:0]     vin [3];
      pin = '{r.pos_x_in, r.pos_y_in, r.pos_z_in};
      vin = '{r.vel_x_in, r.vel_y_in, r.vel_z_in};
      for (int i = 0; i < 3; i++) begin
         pos[i] = longint'($signed(pin[i]));
         vel[i] = longint'($signed(vin[i]));
      end
      life  = longint'($signed(r.life_in));
      dtv   = longint'({33'd0, r.time_step});
      maxl  = {33'd0, r.max_life};
      one   = longint'(1) << FRAC;
      alive = r.alive_in;
      color = 0;
      sz    = 0;
      if (alive) begin
         life = clamp32(life - dtv);
         if (life > 0) begin
            for (int i = 0; i < 3; i++) begin
               g      = longint'($signed(grav_shadow[i]));
               vel[i] = clamp32(vel[i] + ((g * dtv) >>> FRAC));
               pos[i] = clamp32(pos[i] + ((vel[i] * dtv) >>> FRAC));
            end
         end else begin
            alive = 1'b0;
         end
         // blend factor from the remaining life fraction
         if (life <= 0 || maxl == 0) t = one;
         else if (longint'(life) >= longint'(maxl)) t = 0;
         else t = ((maxl - life) << FRAC) / maxl;
         for (int ch = 0; ch < 4; ch++) begin
            color |= (lerp_q(start_color_sh[8*ch +: 8], end_color_sh[8*ch +: 8], t)
                      & 64'hFF) << (8*ch);
         end
         sz = lerp_q(start_size_sh, end_size_sh, t);
      end
      o.alive_out = alive;
      o.pos_x_out = pos[0][31:0];
      o.pos_y_out = pos[1][31:0];
      o.pos_z_out = pos[2][31:0];
      o.vel_x_out = vel[0][31:0];
      o.vel_y_out = vel[1][31:0];
      o.vel_z_out = vel[2][31:0];
      o.life_out  = life[31:0];
      o.color_out = color[31:0];
      o.size_out  = sz[30:0];
      return o;
   endfunction

   function automatic req_payload_type make_particle(bit a, logic [31:0] px, logic [31:0] py,
         logic [31:0] pz, logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
         logic [31:0] life, logic [30:0] maxl, logic [30:0] dt);
      req_payload_type r;
      r = '{a, px, py, pz, vx, vy, vz, life, maxl, dt};
      return r;
   endfunction

   // signed field: extremes, small values, or anything
   function automatic logic [31:0] pick32();
      case ($urandom_range(5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 32'h3_0000) - 32'h1_8000;
         3: return $urandom_range(0, 32'h400_0000) - 32'h200_0000;
         default: return $urandom;
      endcase
   endfunction

   // live particles dominate; life sits around max_life so the blend covers 0..1
   function automatic req_payload_type random_particle();
      req_payload_type r;
      logic [30:0] maxl, dt;
      logic [31:0] life;
      case ($urandom_range(9))
         0: maxl = 31'($urandom);
         1: maxl = ($urandom_range(7) == 0) ? 31'd0 : 31'd1;
         default: maxl = 31'($urandom_range(1, 32'h40_0000));
      endcase
      case ($urandom_range(7))
         0: dt = 31'($urandom);
         1: dt = 31'd0;
         default: dt = 31'($urandom_range(0, 32'h2_0000));
      endcase
      case ($urandom_range(5))
         0: life = $urandom;
         1: life = 32'h8000_0000 + $urandom_range(255);
         default: life = dt + $urandom_range(0, maxl + maxl / 4 + 1) - $urandom_range(0, 2);
      endcase
      r = make_particle($urandom_range(99) < 85, pick32(), pick32(), pick32(),
                        pick32(), pick32(), pick32(), life, maxl, dt);
      return r;
   endfunction

   // offer one item and return at the edge that takes it
   task automatic send_particle(req_payload_type r, bit push_pred, rsp_payload_type typed);
      if (!calm && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      particle_q.push_back(push_pred ? advance_particle(r) : typed);
   endtask

   // wait out every owed result, then the SETTLE margin
   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (particle_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // apb write: setup then access, register taken at the access edge
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= CSR_ADDR_W'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_GRAV_X:      grav_shadow[0] = value;
         REG_GRAV_Y:      grav_shadow[1] = value;
         REG_GRAV_Z:      grav_shadow[2] = value;
         REG_START_COLOR: start_color_sh = value;
         REG_END_COLOR:   end_color_sh = value;
         REG_START_SIZE:  start_size_sh = value[30:0];
         REG_END_SIZE:    end_size_sh = value[30:0];
         default: ;
      endcase
   endtask

   task automatic load_settings(logic [31:0] gx, logic [31:0] gy, logic [31:0] gz,
         logic [31:0] sc, logic [31:0] ec, logic [31:0] ss, logic [31:0] es);
      csr_write(REG_GRAV_X, gx);
      csr_write(REG_GRAV_Y, gy);
      csr_write(REG_GRAV_Z, gz);
      csr_write(REG_START_COLOR, sc);
      csr_write(REG_END_COLOR, ec);
      csr_write(REG_START_SIZE, ss);
      csr_write(REG_END_SIZE, es);
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t mismatch %s expected %h actual %h", $realtime, name, want, got);
         fail_count++;
      end
   endtask

   // result side: compare every accepted item with the oldest expectation
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (particle_q.size() == 0) begin
            $display("%0t unexpected item %h", $realtime, rsp_data);
            fail_count++;
         end else begin
            want = particle_q.pop_front();
            check_field("alive", want.alive_out, rsp_data.alive_out);
            check_field("pos_x", want.pos_x_out, rsp_data.pos_x_out);
            check_field("pos_y", want.pos_y_out, rsp_data.pos_y_out);
            check_field("pos_z", want.pos_z_out, rsp_data.pos_z_out);
            check_field("vel_x", want.vel_x_out, rsp_data.vel_x_out);
            check_field("vel_y", want.vel_y_out, rsp_data.vel_y_out);
            check_field("vel_z", want.vel_z_out, rsp_data.vel_z_out);
            check_field("life", want.life_out, rsp_data.life_out);
            check_field("color", want.color_out, rsp_data.color_out);
            check_field("size", want.size_out, rsp_data.size_out);
         end
      end
   end

   // receiver: random idling, plus a long stall on request
   initial begin
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 23);
         end
      end
   end

   // watchdog: too long with no item moving on either channel
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
         if (quiet >= STALL_MAX) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   typedef struct {
      req_payload_type stim;
      bit              typed;   // expected value written in below
      rsp_payload_type want;
   } directed_row_type;

   initial begin
      directed_row_type rows[$];
      req_payload_type  r;

      grav_shadow    = '{32'd0, 32'd0, 32'd0};
      start_color_sh = START_COLOR_RST;
      end_color_sh   = 32'd0;
      start_size_sh  = START_SIZE_RST;
      end_size_sh    = 31'd0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // dead particle passes through, colour and size forced to zero
      r = make_particle(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 32'hFFFF_FFFF,
                        32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
      rows.push_back('{r, 1'b1, '{1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678,
                     32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'd0, 31'd0}});
      // expiring particle: motion frozen, blend lands on the end values (both zero)
      r = make_particle(1'b1, 32'd100, 32'd200, 32'd300, 32'd4, 32'd5, 32'd6, 32'd5,
                        31'h1_0000, 31'd10);
      rows.push_back('{r, 1'b1, '{1'b0, 32'd100, 32'd200, 32'd300, 32'd4, 32'd5, 32'd6,
                     32'hFFFF_FFFB, 32'd0, 31'd0}});
      // life underflow saturates at the most negative value
      r = make_particle(1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h8000_0000,
                        31'h7FFF_FFFF, 31'h7FFF_FFFF);
      rows.push_back('{r, 1'b1, '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                     32'h8000_0000, 32'd0, 31'd0}});
      // life exactly zero after the step
      r = make_particle(1'b1, 32'd7, 32'd8, 32'd9, 32'd1, 32'd2, 32'd3, 32'h1_0000,
                        31'h2_0000, 31'h1_0000);
      rows.push_back('{r, 1'b1, '{1'b0, 32'd7, 32'd8, 32'd9, 32'd1, 32'd2, 32'd3,
                     32'd0, 32'd0, 31'd0}});
      // fresh particle, life at max: start colour and size
      r = make_particle(1'b1, 32'd0, 32'd0, 32'd0, 32'h1_0000, 32'hFFFF_0000, 32'd0,
                        32'h2_0000, 31'h2_0000, 31'd0);
      rows.push_back('{r, 1'b1, '{1'b1, 32'd0, 32'd0, 32'd0, 32'h1_0000, 32'hFFFF_0000,
                     32'd0, 32'h2_0000, 32'hFFFF_FFFF, 31'h1_0000}});
      // the rest go through the predictor
      rows.push_back('{make_particle(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       31'h7FFF_FFFF, 31'h7FFF_FFFE), 1'b0, '0});
      rows.push_back('{make_particle(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                       31'h7FFF_FFFF, 31'h4000_0000), 1'b0, '0});
      rows.push_back('{make_particle(1'b1, 32'd1, 32'd2, 32'd3, 32'h1_8000, 32'hFFFE_8000,
                       32'd0, 32'h3_0000, 31'd0, 31'h8000), 1'b0, '0});   // zero max life
      rows.push_back('{make_particle(1'b1, 32'd5, 32'd6, 32'd7, 32'hFFFF_FFFF, 32'd1, 32'd2,
                       32'h5_0000, 31'h2_0000, 31'h1_0000), 1'b0, '0});   // life above max
      rows.push_back('{make_particle(1'b1, 32'hFFFF_0000, 32'd0, 32'h1_0000, 32'h3_0000,
                       32'h8000_0001, 32'h7FFF_0000, 32'h1_0000, 31'h3_0000, 31'd0),
                       1'b0, '0});                                        // zero time step
      rows.push_back('{make_particle(1'b1, 32'd0, 32'd0, 32'd0, 32'd3, 32'hFFFF_FFFD, 32'd1,
                       32'd2, 31'h7FFF_FFFF, 31'd1), 1'b0, '0});          // tiny life, t near 1
      rows.push_back('{make_particle(1'b1, 32'h1000, 32'h2000, 32'h3000, 32'd0, 32'd0, 32'd0,
                       32'h1_8000, 31'h2_0000, 31'h8000), 1'b0, '0});     // half way
      rows.push_back('{make_particle(1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                       32'h8000_0000, 31'd0, 31'd0), 1'b0, '0});

      foreach (rows[i]) send_particle(rows[i].stim, !rows[i].typed, rows[i].want);
      drain_pipe();

      // settings phases, extremes first
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: load_settings(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
            1: load_settings(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0,
                             32'd0, 32'd0);
            2: load_settings(32'hFFF6_3000, 32'd0, 32'h0009_CD00, 32'hFF80_2000,
                             32'h00FF_40FF, 32'h0002_0000, 32'h7FFF_FFFF);
            default: load_settings(pick32(), pick32(), pick32(), $urandom, $urandom,
                                   $urandom, $urandom);
         endcase
         calm = (ph == 3);
         if (ph == 2) hold_reqs++;   // receiver stalls while items keep coming
         for (int n = 0; n < PHASE_LEN; n++)
            send_particle(random_particle(), 1'b1, '0);
         calm = 1'b0;
         drain_pipe();               // sender waits for every owed result
      end

      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
